### rtl/core/count_min_sketch_macros.svh
// Assertion macros used by the count-min sketch top level.
`ifndef COUNT_MIN_SKETCH_MACROS_SVH
`define COUNT_MIN_SKETCH_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define CMS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/core/cms_pkg.sv
// Types and constants of the count-min sketch.
`timescale 1ns / 1ps
`default_nettype none
package cms_pkg;
   localparam int ROWS = 4;
   localparam int COLS = 1024;
   localparam int COL_BITS = $clog2(COLS);
   localparam int CHAIN_BITS = $clog2(ROWS + 1);

   localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;
   localparam logic signed [31:0] EST_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] EST_MIN = 32'sh80000000;
   localparam logic [2:0] ROWS_RESET = 3'd4;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH1,
      ST_HASH2,
      ST_ADDR,
      ST_READ,
      ST_CHAIN
   } state_type;

   typedef struct packed {
      logic                hash1;
      logic                hash2;
      logic                modify;
      logic                chain;
      logic                clear;
      logic [COL_BITS-1:0] clr_addr;
      cmd_type             cmd;
      logic [31:0]         key;
   } ctl_type;
endpackage
`default_nettype wire

### rtl/core/cms_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

### rtl/core/cms_cell.sv
// One sketch row: hash, counter bank, update and one link of the minimum chain.
`timescale 1ns / 1ps
`default_nettype none
module cms_cell
   import cms_pkg::*;
(
   input  wire logic               clock,
   input  wire ctl_type            ctl,
   input  wire logic [31:0]        row_seed,
   input  wire logic               used,
   input  wire logic signed [31:0] min_in,
   output logic signed [31:0]      min_out
);
   logic [31:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [31:0] h0, a, b, h;
   logic [COL_BITS-1:0] col;
   logic signed [31:0] rdata, newv, val_ff, val_in, min_ff, min_in_next;
   logic we;
   logic [COL_BITS-1:0] waddr;
   logic [31:0] wdata;

   always_comb begin
      h0 = ctl.key ^ row_seed;
      a = h0 ^ (h0 >> 16);
      p1_in = ctl.hash1 ? a * FMIX_C1 : p1_ff;
      b = p1_ff ^ (p1_ff >> 13);
      p2_in = ctl.hash2 ? b * FMIX_C2 : p2_ff;
      h = p2_ff ^ (p2_ff >> 16);
      col = COL_BITS'(h % COLS);
   end

   always_comb begin
      unique case (ctl.cmd)
         CMD_INSERT: newv = (rdata == EST_MAX) ? rdata : rdata + 32'sd1;
         CMD_REMOVE: newv = (rdata == EST_MIN) ? rdata : rdata - 32'sd1;
         default:    newv = rdata;
      endcase
   end

   assign we = ctl.clear
             | (ctl.modify & used & ((ctl.cmd == CMD_INSERT) | (ctl.cmd == CMD_REMOVE)));
   assign waddr = ctl.clear ? ctl.clr_addr : col;
   assign wdata = ctl.clear ? 32'd0 : 32'(newv);

   cms_ram #(.WIDTH(32), .DEPTH(COLS)) u_bank (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (col),
      .rdata (rdata)
   );

   // pass the smaller of the upstream minimum and this row's counter (the upstream minimum when the row is unused)
   assign val_in = ctl.modify ? rdata : val_ff;
   assign min_in_next = ctl.chain ? ((used && (val_ff < min_in)) ? val_ff : min_in) : min_ff;

   always_ff @(posedge clock) begin
      p1_ff  <= p1_in;
      p2_ff  <= p2_in;
      val_ff <= val_in;
      min_ff <= min_in_next;
   end

   assign min_out = min_ff;
endmodule
`default_nettype wire

### rtl/core/count_min_sketch.sv
// Top level of the count-min sketch: control sequencer and the row of cells.
//
//  channel | direction | handshake         | beat
//  req     | in        | req_valid/stall   | cmd, key
//  rsp     | out       | rsp_valid/stall   | estimate (queries only)
//  csr     | in        | csr_valid/ready   | rows_in_use
//
// An insert, remove or unused command passes two hash multiplies, bank read
// and update; a query then also walks its minimum one cell per cycle down
// the row chain. After reset every column of the banks (COLS, 1024) is
// cleared before the first item is taken. A stalled result holds the query
// at its last chain step; new items wait until then.
`timescale 1ns / 1ps
`default_nettype none
`include "count_min_sketch_macros.svh"
module count_min_sketch
   import cms_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_estimate,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_rows_in_use
);
   state_type state_ff, state_in;
   logic [COL_BITS-1:0]   clr_ff, clr_in;
   logic [CHAIN_BITS-1:0] chain_ff, chain_in;
   logic [2:0]            rows_ff, rows_in;
   cmd_type               cmd_ff, cmd_in;
   logic [31:0]           key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    est_ff, est_in;
   logic                  accept, chain_end, load;
   ctl_type               ctl;
   logic signed [31:0]    min_link [ROWS+1];

   assign accept = req_valid && !req_stall;
   assign chain_end = (chain_ff == CHAIN_BITS'(ROWS));
   assign load = (state_ff == ST_CHAIN) && chain_end && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == COL_BITS'(COLS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_HASH1;
         ST_HASH1: state_in = ST_HASH2;
         ST_HASH2: state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_READ;
         ST_READ:  state_in = (cmd_ff == CMD_QUERY) ? ST_CHAIN : ST_IDLE;
         ST_CHAIN: if (load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      csr_ready    = 1'b1;
      ctl.hash1    = (state_ff == ST_HASH1);
      ctl.hash2    = (state_ff == ST_HASH2);
      ctl.modify   = (state_ff == ST_READ);
      ctl.chain    = (state_ff == ST_CHAIN);
      ctl.clear    = (state_ff == ST_CLEAR);
      ctl.clr_addr = clr_ff;
      ctl.cmd      = cmd_ff;
      ctl.key      = key_ff;
   end

   always_comb begin
      clr_in   = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      chain_in = (state_ff == ST_CHAIN) ? (chain_end ? chain_ff : chain_ff + 1'b1)
                                        : '0;
      rows_in  = (csr_valid && csr_ready) ? csr_rows_in_use : rows_ff;
      cmd_in   = accept ? cmd_type'(req_cmd) : cmd_ff;
      key_in   = accept ? req_key : key_ff;
      est_in   = load ? min_link[ROWS] : est_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chain_ff     <= '0;
         rows_ff      <= ROWS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chain_ff     <= chain_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      key_ff <= key_in;
      est_ff <= est_in;
   end

   assign min_link[0] = EST_MAX;

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      cms_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .row_seed (32'(r)),
         .used     (32'(r) < 32'(rows_ff)),
         .min_in   (min_link[r]),
         .min_out  (min_link[r+1])
      );
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = est_ff;

   `CMS_ASSERT_NEXT(a_accept_starts_hash, clock, reset, accept, state_ff == ST_HASH1)
   `CMS_ASSERT_SAME(a_no_result_while_clearing, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff)
   `CMS_ASSERT_SAME(a_result_from_chain, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_CHAIN)
endmodule
`default_nettype wire

### test/count_min_sketch_tb.sv
// Self-checking testbench of the count-min sketch: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class sketch_board;
   int signed counts [cms_pkg::ROWS * cms_pkg::COLS];
   logic [2:0] rows_cfg;
   int signed estimates [$];
   int errors;

   function new();
      foreach (counts[i]) counts[i] = 0;
      rows_cfg = cms_pkg::ROWS_RESET;
      errors = 0;
   endfunction

   function automatic logic [31:0] mix(logic [31:0] key, logic [31:0] row);
      logic [31:0] h;
      h = key ^ row;
      h = h ^ (h >> 16);
      h = h * 32'h85ebca6b;
      h = h ^ (h >> 13);
      h = h * 32'hc2b2ae35;
      h = h ^ (h >> 16);
      return h;
   endfunction

   function automatic int slot(logic [31:0] key, int row);
      return row * cms_pkg::COLS + int'(mix(key, row) % cms_pkg::COLS);
   endfunction

   // update the counters and queue a query's minimum
   function void note_item(cms_pkg::cmd_type cmd, logic [31:0] key);
      int n;
      int signed low;
      int s;
      n = (rows_cfg > cms_pkg::ROWS) ? cms_pkg::ROWS : rows_cfg;
      low = cms_pkg::EST_MAX;
      for (int r = 0; r < n; r++) begin
         s = slot(key, r);
         case (cmd)
            cms_pkg::CMD_INSERT: if (counts[s] != cms_pkg::EST_MAX) counts[s]++;
            cms_pkg::CMD_REMOVE: if (counts[s] != cms_pkg::EST_MIN) counts[s]--;
            cms_pkg::CMD_QUERY: if (counts[s] < low) low = counts[s];
            default: ;
         endcase
      end
      if (cmd == cms_pkg::CMD_QUERY) estimates.push_back(low);
   endfunction

   function void check_estimate(logic signed [31:0] got);
      int signed want;
      if (estimates.size() == 0) begin
         $display("%0t: unexpected estimate, expected none, actual %0d", $time, got);
         errors++;
         return;
      end
      want = estimates.pop_front();
      if (got !== want) begin
         $display("%0t: estimate mismatch, expected %0d, actual %0d", $time, want, got);
         errors++;
      end
   endfunction
endclass

module count_min_sketch_tb;
   import cms_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_cmd = 0;
   logic [31:0] req_key = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [31:0] rsp_estimate;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_rows_in_use = 0;

   sketch_board board;
   bit quiet = 0;       // no idling in the final stretch
   bit hold_rsp = 0;    // long receiver hold-off request
   int idle_count = 0;
   logic [31:0] hot_keys [8];

   count_min_sketch dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_item(cmd_type'(req_cmd), req_key);
         if (rsp_valid && !rsp_stall) board.check_estimate(rsp_estimate);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
               || (!req_valid && board.estimates.size() == 0))
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count > 20000) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver stall in random bursts, plus one long hold-off
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1;
            for (n = 0; n < 60; n++) @(negedge clock);
            hold_rsp = 0;
            rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_item(cmd_type cmd, logic [31:0] key);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_key <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.estimates.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_rows(logic [2:0] rows);
      drain();
      csr_valid <= 1;
      csr_rows_in_use <= rows;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.rows_cfg = rows;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_item();
      logic [31:0] key;
      int pick;
      key = ($urandom_range(0, 3) == 0) ? $urandom() : hot_keys[$urandom_range(0, 7)];
      pick = $urandom_range(0, 19);
      if (pick < 8) send_item(CMD_INSERT, key);
      else if (pick < 12) send_item(CMD_REMOVE, key);
      else if (pick < 19) send_item(CMD_QUERY, key);
      else send_item(CMD_NONE, key);
   endtask

   initial begin
      logic [2:0] settings [6];
      settings = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
      board = new();
      foreach (hot_keys[i]) hot_keys[i] = $urandom();
      repeat (7) @(negedge clock);
      reset <= 0;

      // directed: field extremes, every command, unused command
      send_item(CMD_QUERY, 32'h0);
      send_item(CMD_INSERT, 32'h0);
      send_item(CMD_INSERT, 32'h0);
      send_item(CMD_QUERY, 32'h0);
      send_item(CMD_INSERT, 32'hffffffff);
      send_item(CMD_REMOVE, 32'hffffffff);
      send_item(CMD_REMOVE, 32'hffffffff);
      send_item(CMD_QUERY, 32'hffffffff);
      send_item(CMD_NONE, 32'h0);
      send_item(CMD_NONE, 32'hffffffff);
      send_item(CMD_QUERY, 32'h0);
      send_item(CMD_QUERY, 32'h55555555);
      send_item(CMD_REMOVE, 32'haaaaaaaa);
      send_item(CMD_QUERY, 32'haaaaaaaa);

      // sender keeps offering while the receiver holds off
      hold_rsp = 1;
      repeat (20) send_item(CMD_QUERY, hot_keys[$urandom_range(0, 7)]);
      // pause until every estimate is back
      drain();

      foreach (settings[s]) begin
         write_rows(settings[s]);
         repeat (100) random_item();
      end
      quiet = 1;
      repeat (60) random_item();

      drain();
      if (board.estimates.size() == 0 && board.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/cms_pkg.sv
rtl/core/cms_ram.sv
rtl/core/cms_cell.sv
rtl/core/count_min_sketch.sv
test/count_min_sketch_tb.sv
